// ----- rtl/uirb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uirb_pkg
// Shared widths, mode codes and controller/datapath interface types for the
// UART interrupt ring buffer block.
// ----------------------------------------------------------------------------
package uirb_pkg;

	localparam int UIRB_RING_DEPTH = 64;

	localparam int MODE_W      = 2;
	localparam int BYTE_W      = 8;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 24;

	localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GET   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EVENT = 2'd2;

	typedef struct packed {
		logic load_item;
		logic exec;
		logic load_out;
	} uirb_cmd_t;

	typedef struct packed {
		logic out_free;
	} uirb_status_t;

endpackage
`default_nettype wire

// ----- rtl/uirb_ring.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uirb_ring
// Byte ring: memory with slot pointers and lap bits, one push and one pop
// port, registered read data.
// ----------------------------------------------------------------------------
module uirb_ring #(
	parameter int RING_DEPTH = uirb_pkg::UIRB_RING_DEPTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire logic                        pop,
	input  wire logic [uirb_pkg::BYTE_W-1:0] wr_data,
	output logic                             full,
	output logic                             empty,
	output logic [uirb_pkg::BYTE_W-1:0]      rd_data
);
	import uirb_pkg::*;

	localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

	logic [BYTE_W-1:0] mem_q [RING_DEPTH];
	logic [BYTE_W-1:0] rd_data_q;
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     tail_q;
	logic              head_lap_q;
	logic              tail_lap_q;

	assign empty   = (head_q == tail_q) && (head_lap_q == tail_lap_q);
	assign full    = (head_q == tail_q) && (head_lap_q != tail_lap_q);
	assign rd_data = rd_data_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail_q] <= wr_data;
		end
		if (pop) begin
			rd_data_q <= mem_q[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			head_lap_q <= 1'b0;
			tail_lap_q <= 1'b0;
		end else begin
			if (push) begin
				if (tail_q == LAST_SLOT) begin
					tail_q     <= '0;
					tail_lap_q <= ~tail_lap_q;
				end else begin
					tail_q <= tail_q + AW'(1);
				end
			end
			if (pop) begin
				if (head_q == LAST_SLOT) begin
					head_q     <= '0;
					head_lap_q <= ~head_lap_q;
				end else begin
					head_q <= head_q + AW'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/uirb_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uirb_datapath
// Item register, receive and transmit rings, interrupt-enable and fault bits,
// and the result register.
// ----------------------------------------------------------------------------
module uirb_datapath #(
	parameter int RING_DEPTH = uirb_pkg::UIRB_RING_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire uirb_pkg::uirb_cmd_t              cmd,
	output uirb_pkg::uirb_status_t                status,
	input  wire logic [uirb_pkg::IN_TDATA_W-1:0]  in_tdata,
	input  wire logic [uirb_pkg::MODE_W-1:0]      in_tuser,
	output logic                                  out_tvalid,
	input  wire logic                             out_tready,
	output logic [uirb_pkg::OUT_TDATA_W-1:0]      out_tdata
);
	import uirb_pkg::*;

	logic [MODE_W-1:0] mode_q;
	logic [BYTE_W-1:0] byte_q;
	logic              ready_q;
	logic              thre_q;
	logic              ovr_q;

	logic rx_en_q;
	logic tx_en_q;
	logic halted_q;

	logic read_valid_q;
	logic write_acc_q;
	logic recv_q;
	logic send_valid_q;

	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_q;

	logic              rx_full, rx_empty, tx_full, tx_empty;
	logic [BYTE_W-1:0] rx_rd_data, tx_rd_data;
	logic              is_put, is_get, is_evt, is_ovr;
	logic              rx_push, rx_pop, tx_push, tx_pop;
	logic              rx_drop, tx_idle;
	logic [BYTE_W-1:0] read_byte, send_byte;

	assign is_put  = !halted_q && (mode_q == MODE_PUT);
	assign is_get  = !halted_q && (mode_q == MODE_GET);
	assign is_ovr  = !halted_q && (mode_q == MODE_EVENT) && ovr_q;
	assign is_evt  = !halted_q && (mode_q == MODE_EVENT) && !ovr_q;

	assign tx_push = cmd.exec && is_put && !tx_full;
	assign rx_pop  = cmd.exec && is_get && !rx_empty;
	assign rx_push = cmd.exec && is_evt && ready_q && !rx_full;
	assign tx_pop  = cmd.exec && is_evt && thre_q && !tx_empty;
	assign rx_drop = cmd.exec && is_evt && ready_q && rx_full;
	assign tx_idle = cmd.exec && is_evt && thre_q && tx_empty;

	uirb_ring #(.RING_DEPTH(RING_DEPTH)) u_rx_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (rx_push),
		.pop     (rx_pop),
		.wr_data (byte_q),
		.full    (rx_full),
		.empty   (rx_empty),
		.rd_data (rx_rd_data)
	);

	uirb_ring #(.RING_DEPTH(RING_DEPTH)) u_tx_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (tx_push),
		.pop     (tx_pop),
		.wr_data (byte_q),
		.full    (tx_full),
		.empty   (tx_empty),
		.rd_data (tx_rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q  <= in_tuser;
			byte_q  <= in_tdata[7:0];
			ready_q <= in_tdata[8];
			thre_q  <= in_tdata[9];
			ovr_q   <= in_tdata[10];
		end
		if (cmd.exec) begin
			read_valid_q <= rx_pop;
			write_acc_q  <= tx_push;
			recv_q       <= rx_push;
			send_valid_q <= tx_pop;
		end
		if (cmd.load_out) begin
			out_q <= {1'b0, halted_q, tx_en_q, rx_en_q, send_valid_q, send_byte,
				recv_q, write_acc_q, read_valid_q, read_byte};
		end
	end

	assign read_byte = read_valid_q ? rx_rd_data : '0;
	assign send_byte = send_valid_q ? tx_rd_data : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_en_q     <= 1'b1;
			tx_en_q     <= 1'b0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rx_pop) begin
				rx_en_q <= 1'b1;
			end else if (rx_drop) begin
				rx_en_q <= 1'b0;
			end
			if (tx_push) begin
				tx_en_q <= 1'b1;
			end else if (tx_idle) begin
				tx_en_q <= 1'b0;
			end
			if (cmd.exec && is_ovr) begin
				halted_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.out_free = !out_valid_q || out_tready;
	assign out_tvalid      = out_valid_q;
	assign out_tdata       = out_q;

endmodule
`default_nettype wire

// ----- rtl/uirb_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uirb_ctrl
// Item sequencer: take an item, execute it against the rings, load the
// result register.
// ----------------------------------------------------------------------------
module uirb_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_tvalid,
	output logic                        in_tready,
	input  wire uirb_pkg::uirb_status_t status,
	output uirb_pkg::uirb_cmd_t         cmd
);
	import uirb_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d       = state_q;
		cmd.load_item = 1'b0;
		cmd.exec      = 1'b0;
		cmd.load_out  = 1'b0;
		in_tready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_tready     = 1'b1;
				cmd.load_item = in_tvalid;
				if (in_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_LOAD;
			end
			ST_LOAD: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/uart_interrupt_ring_buffers.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uart_interrupt_ring_buffers
// Receive and transmit byte rings with interrupt-enable tracking for a
// 16550-style UART; one result item per input item.
//
// channel  dir  tdata                                             tuser
// s_*      in   data_byte, status_ready, status_tx_empty,         mode
//               status_overrun
// m_*      out  read_byte, read_valid, write_accepted,            -
//               received_taken, send_byte, send_valid,
//               rx_irq_enable, tx_irq_enable, fault
//
// Each item passes the item register at accept, the ring push/pop edge
// (registered memory read) and the result register load; the result is
// valid once the result register is loaded.
// The sequencer handles one item at a time; it accepts the next only after the result load.
// A held result stalls the sequencer in its load step only.
// Reset empties both rings at once, sets rx enable, clears the other flags.
// ----------------------------------------------------------------------------
module uart_interrupt_ring_buffers #(
	parameter int RING_DEPTH = uirb_pkg::UIRB_RING_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// [7:0] data_byte, [8] status_ready, [9] status_tx_empty,
	// [10] status_overrun, [15:11] zero
	input  wire logic [uirb_pkg::IN_TDATA_W-1:0]  s_tdata,
	// [1:0] mode
	input  wire logic [uirb_pkg::MODE_W-1:0]      s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [7:0] read_byte, [8] read_valid, [9] write_accepted, [10] received_taken,
	// [18:11] send_byte, [19] send_valid, [20] rx_irq_enable,
	// [21] tx_irq_enable, [22] fault, [23] zero
	output logic [uirb_pkg::OUT_TDATA_W-1:0]      m_tdata
);
	import uirb_pkg::*;

	uirb_cmd_t    cmd;
	uirb_status_t status;

	uirb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tvalid (s_tvalid),
		.in_tready (s_tready),
		.status    (status),
		.cmd       (cmd)
	);

	uirb_datapath #(.RING_DEPTH(RING_DEPTH)) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_tdata   (s_tdata),
		.in_tuser   (s_tuser),
		.out_tvalid (m_tvalid),
		.out_tready (m_tready),
		.out_tdata  (m_tdata)
	);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (!s_tready && cmd.exec))
		else $error("item accepted while another is in progress");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> status.out_free)
		else $error("result register overwritten");

	a_one_host_op: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[8] && m_tdata[9]))
		else $error("get and put reported on one item");

	a_fault_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[22]) |->
		(!m_tdata[8] && !m_tdata[9] && !m_tdata[10] && !m_tdata[19]))
		else $error("ring activity reported while halted");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[8]) |-> (m_tdata[7:0] == 8'd0))
		else $error("read byte not cleared on empty get");

endmodule
`default_nettype wire

// ----- dv/tb_uart_interrupt_ring_buffers.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_uart_interrupt_ring_buffers
// Stream-level testbench for the UART interrupt ring buffer block. It drives
// host puts, host gets and line-status events, predicts every result item
// from its own copy of both rings and the interrupt-enable bits, and checks
// each result field by field. It covers full and empty rings, ignored modes,
// random stalls on both sides, a long output hold-off and a final overrun halt.
// ----------------------------------------------------------------------------
module tb_uart_interrupt_ring_buffers;
	import uirb_pkg::*;

	localparam int DEPTH = UIRB_RING_DEPTH;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 317;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic              pad;
		logic              fault;
		logic              tx_irq_enable;
		logic              rx_irq_enable;
		logic              send_valid;
		logic [BYTE_W-1:0] send_byte;
		logic              received_taken;
		logic              write_accepted;
		logic              read_valid;
		logic [BYTE_W-1:0] read_byte;
	} uart_result_t;

	class ring_scoreboard;
		logic [BYTE_W-1:0] rx_ring[DEPTH];
		logic [BYTE_W-1:0] tx_ring[DEPTH];
		int rx_rd, rx_wr, tx_rd, tx_wr;
		logic rx_en, tx_en, halted;
		uart_result_t owed_results[$];
		int errors;

		function new();
			rx_rd = 0;
			rx_wr = 0;
			tx_rd = 0;
			tx_wr = 0;
			rx_en = 1'b1;
			tx_en = 1'b0;
			halted = 1'b0;
			errors = 0;
		endfunction

		function int fill(int rd, int wr);
			return (wr >= rd) ? wr - rd : wr + 2 * DEPTH - rd;
		endfunction

		function int bump(int p);
			return (p == 2 * DEPTH - 1) ? 0 : p + 1;
		endfunction

		function void note_item(logic [MODE_W-1:0] md, logic [BYTE_W-1:0] data,
				logic rdy, logic thr, logic ovr);
			uart_result_t r;
			r = '0;
			if (!halted) begin
				case (md)
				MODE_PUT: begin
					if (fill(tx_rd, tx_wr) != DEPTH) begin
						tx_ring[tx_wr % DEPTH] = data;
						tx_wr = bump(tx_wr);
						r.write_accepted = 1'b1;
						tx_en = 1'b1;
					end
				end
				MODE_GET: begin
					if (fill(rx_rd, rx_wr) != 0) begin
						r.read_byte = rx_ring[rx_rd % DEPTH];
						rx_rd = bump(rx_rd);
						r.read_valid = 1'b1;
						rx_en = 1'b1;
					end
				end
				MODE_EVENT: begin
					if (ovr) begin
						halted = 1'b1;
					end else begin
						if (rdy) begin
							if (fill(rx_rd, rx_wr) != DEPTH) begin
								rx_ring[rx_wr % DEPTH] = data;
								rx_wr = bump(rx_wr);
								r.received_taken = 1'b1;
							end else begin
								rx_en = 1'b0;
							end
						end
						if (thr) begin
							if (fill(tx_rd, tx_wr) != 0) begin
								r.send_byte = tx_ring[tx_rd % DEPTH];
								tx_rd = bump(tx_rd);
								r.send_valid = 1'b1;
							end else begin
								tx_en = 1'b0;
							end
						end
					end
				end
				default: ;
				endcase
			end
			r.rx_irq_enable = rx_en;
			r.tx_irq_enable = tx_en;
			r.fault = halted;
			owed_results.push_back(r);
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0h, actual %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] tdata);
			uart_result_t got, want;
			got = uart_result_t'(tdata);
			if (owed_results.size() == 0) begin
				$error("result item with no item pending: %0h", tdata);
				errors++;
				return;
			end
			want = owed_results.pop_front();
			check_field("read_byte", want.read_byte, got.read_byte);
			check_field("read_valid", want.read_valid, got.read_valid);
			check_field("write_accepted", want.write_accepted, got.write_accepted);
			check_field("received_taken", want.received_taken, got.received_taken);
			check_field("send_byte", want.send_byte, got.send_byte);
			check_field("send_valid", want.send_valid, got.send_valid);
			check_field("rx_irq_enable", want.rx_irq_enable, got.rx_irq_enable);
			check_field("tx_irq_enable", want.tx_irq_enable, got.tx_irq_enable);
			check_field("fault", want.fault, got.fault);
			check_field("pad", want.pad, got.pad);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [MODE_W-1:0]      s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int tx_idle_pct = 32;
	int rx_idle_pct = 63;
	bit hold_off_req = 1'b0;
	ring_scoreboard sb = new();

	uart_interrupt_ring_buffers u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata);
			end
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic send_item(input logic [MODE_W-1:0] md, input logic [BYTE_W-1:0] data,
			input logic rdy, input logic thr, input logic ovr);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= md;
		s_tdata <= {5'd0, ovr, thr, rdy, data};
		do @(posedge clk); while (!s_tready);
		sb.note_item(md, data, rdy, thr, ovr);
	endtask

	task automatic run_bursts(input int count);
		int done_n, kind, len;
		logic [MODE_W-1:0] md;
		logic rdy, thr;
		done_n = 0;
		while (done_n < count) begin
			kind = $urandom_range(4);
			len = (kind == 4) ? $urandom_range(1, 30) : $urandom_range(1, 80);
			for (int i = 0; i < len && done_n < count; i++) begin
				rdy = ($urandom_range(3) == 0);
				thr = ($urandom_range(3) == 0);
				case (kind)
				0: md = MODE_PUT;
				1: begin
					md = MODE_EVENT;
					thr = 1'b1;
				end
				2: begin
					md = MODE_EVENT;
					rdy = 1'b1;
				end
				3: md = MODE_GET;
				default: begin
					md = ($urandom_range(19) == 0) ? MODE_UNUSED : MODE_W'($urandom_range(2));
					rdy = 1'($urandom_range(1));
					thr = 1'($urandom_range(1));
				end
				endcase
				send_item(md, BYTE_W'($urandom_range(255)), rdy, thr, 1'b0);
				if (md != MODE_UNUSED) done_n++;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(MODE_GET, 8'hFF, 1'b1, 1'b1, 1'b1);
		send_item(MODE_EVENT, 8'h00, 1'b0, 1'b1, 1'b0);
		send_item(MODE_PUT, 8'h00, 1'b1, 1'b1, 1'b1);
		send_item(MODE_PUT, 8'hFF, 1'b0, 1'b0, 1'b0);
		send_item(MODE_EVENT, 8'hA5, 1'b1, 1'b1, 1'b0);
		send_item(MODE_EVENT, 8'h5A, 1'b0, 1'b1, 1'b0);
		send_item(MODE_EVENT, 8'h11, 1'b0, 1'b1, 1'b0);
		send_item(MODE_EVENT, 8'h00, 1'b1, 1'b0, 1'b0);
		send_item(MODE_EVENT, 8'hFF, 1'b1, 1'b0, 1'b0);
		send_item(MODE_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1);
		send_item(MODE_GET, 8'h00, 1'b0, 1'b0, 1'b0);
		send_item(MODE_GET, 8'hFF, 1'b1, 1'b1, 1'b1);
		send_item(MODE_GET, 8'h3C, 1'b0, 1'b1, 1'b0);
		send_item(MODE_GET, 8'h3C, 1'b0, 1'b0, 1'b0);
		send_item(MODE_EVENT, 8'h77, 1'b0, 1'b0, 1'b0);
		send_item(MODE_PUT, 8'h5A, 1'b0, 1'b0, 1'b1);
		send_item(MODE_EVENT, 8'h3C, 1'b1, 1'b1, 1'b0);
		send_item(MODE_UNUSED, 8'h00, 1'b0, 1'b0, 1'b0);
		send_item(MODE_GET, 8'h00, 1'b0, 1'b0, 1'b0);

		run_bursts(PHASE_ITEMS);
		tx_idle_pct = 63;
		rx_idle_pct = 32;
		run_bursts(PHASE_ITEMS);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_off_req = 1'b1;
		run_bursts(PHASE_ITEMS);

		send_item(MODE_PUT, 8'hC3, 1'b0, 1'b0, 1'b0);
		send_item(MODE_EVENT, 8'h96, 1'b1, 1'b1, 1'b1);
		send_item(MODE_PUT, 8'h81, 1'b0, 1'b0, 1'b0);
		send_item(MODE_GET, 8'h00, 1'b0, 1'b0, 1'b0);
		send_item(MODE_EVENT, 8'h42, 1'b1, 1'b1, 1'b0);
		send_item(MODE_EVENT, 8'h24, 1'b0, 1'b0, 1'b1);
		send_item(MODE_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1);
		s_tvalid <= 1'b0;

		while (sb.owed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/uirb_pkg.sv
rtl/uirb_ring.sv
rtl/uirb_datapath.sv
rtl/uirb_ctrl.sv
rtl/uart_interrupt_ring_buffers.sv
dv/tb_uart_interrupt_ring_buffers.sv
